### hw/rtl/hlcd_pkg.sv
package hlcd_pkg;

  // Frame size bounds and derived storage widths.
  localparam int unsigned FrameMax = 64;
  localparam int unsigned FrameMin = 8;
  localparam int unsigned AddrW    = $clog2(FrameMax);
  localparam int unsigned CntW     = $clog2(FrameMax + 1);

  // Register indexes of the configuration port.
  localparam logic RegHeader = 1'b0;
  localparam logic RegLimit  = 1'b1;

  // Configuration as seen by the scanner; lim is already clamped to FrameMax.
  typedef struct packed {
    logic [7:0]      header;
    logic [CntW-1:0] lim;
  } cfg_t;

  // Request bundle toward the byte buffer.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

endpackage

### hw/rtl/header_length_checksum_deframer.sv
// The word that completes a frame is checked in StProc; its header word is then read in
// StErd and shown in StEout. Each received word is taken in StIdle, checked in StProc;
// no new word is taken until all buffered words are scanned. A rescanned word is read in
// StRead and checked in StProc. Each frame word is read in StErd and waits in StEout.
// Reset: asynchronous, active low; clears the scanner and loads header 0x3A, limit 64.
// The byte buffer contents are not cleared and only written entries are ever read.
module header_length_checksum_deframer import hlcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] frame_byte, [13:8] byte_position, [15:14] zero
  output logic        m_tlast
);

  logic [7:0]      header_q;
  logic [6:0]      limit_q;
  cfg_t            cfg;
  ram_req_t        ram_req;
  logic [7:0]      ram_rdata;
  logic [7:0]      out_byte;
  logic [5:0]      out_pos;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= 8'h3A;
      limit_q  <= 7'(FrameMax);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegHeader: header_q <= cfg_wdata_i;
        RegLimit:  limit_q  <= cfg_wdata_i[6:0];
        default:   ;
      endcase
    end
  end

  // Limits above the buffer depth act as the buffer depth.
  assign cfg.header = header_q;
  assign cfg.lim    = (limit_q > 7'(FrameMax)) ? CntW'(FrameMax) : CntW'(limit_q);

  hlcd_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .in_byte_i   (s_tdata),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_byte_o  (out_byte),
    .out_pos_o   (out_pos),
    .out_last_o  (m_tlast),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  hlcd_ram #(
    .Width (8),
    .Depth (FrameMax)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  assign m_tdata = {2'b00, out_pos, out_byte};

endmodule

### hw/rtl/hlcd_ram.sv
module hlcd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one read port with registered data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/hlcd_scan.sv
module hlcd_scan import hlcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [5:0] out_pos_o,
  output logic       out_last_o,
  output ram_req_t   ram_req_o,
  input  logic [7:0] ram_rdata_i
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StRead = 5'b00010,
    StProc = 5'b00100,
    StErd  = 5'b01000,
    StEout = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [AddrW-1:0] head_q, head_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  avail_q, avail_d;
  logic [5:0]       idx_q, idx_d;
  logic             byp_sel_q, byp_sel_d;
  logic [7:0]       byp_q, byp_d;
  logic [15:0]      sum_q, sum_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       sh_q [4];
  logic [7:0]       sh_d [4];

  logic [7:0]       cur_byte;
  logic [AddrW-1:0] scan_addr;
  logic             grow_rej;
  logic             len_rej;
  logic             frame_done;
  logic [15:0]      sum_new;
  logic             sum_ok;
  logic [CntW-1:0]  last_pos;
  logic             emit_last;

  // The buffer holds the open frame from head on, then the unscanned words.
  assign scan_addr = head_q + cnt_q[AddrW-1:0];
  assign cur_byte  = byp_sel_q ? byp_q : ram_rdata_i;

  // Frame checks for the word being appended at position cnt_q.
  assign grow_rej   = (cnt_q >= cfg_i.lim);
  assign len_rej    = (({1'b0, len_q} + 9'(FrameMin)) > {2'b00, cfg_i.lim});
  assign frame_done = ({2'b00, cnt_q} == ({1'b0, len_q} + 9'(FrameMin - 1)));
  assign sum_new    = sum_q + ((cnt_q >= CntW'(5)) ? {8'h00, sh_q[3]} : 16'h0000);
  assign sum_ok     = (sum_new == {sh_q[1], sh_q[2]});

  assign last_pos  = cnt_q - CntW'(1);
  assign emit_last = ({1'b0, idx_q} == last_pos);

  // Handshake and output fields.
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StEout);
  assign out_byte_o  = ram_rdata_i;
  assign out_pos_o   = idx_q;
  assign out_last_o  = emit_last;

  // Sequencer: one word is read and then processed, frames are read out in order.
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    avail_d   = avail_q;
    idx_d     = idx_q;
    byp_sel_d = byp_sel_q;
    byp_d     = byp_q;
    sum_d     = sum_q;
    len_d     = len_q;
    sh_d      = sh_q;
    ram_req_o = '0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = scan_addr;
          ram_req_o.wdata = in_byte_i;
          byp_d           = in_byte_i;
          byp_sel_d       = 1'b1;
          avail_d         = CntW'(1);
          state_d         = StProc;
        end
      end

      StRead: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = scan_addr;
        byp_sel_d       = 1'b0;
        state_d         = StProc;
      end

      StProc: begin
        if (cnt_q == '0) begin
          // No open frame: a header word opens one, anything else is dropped.
          avail_d = avail_q - CntW'(1);
          if (cur_byte == cfg_i.header) begin
            cnt_d = CntW'(1);
            sum_d = '0;
          end else begin
            head_d = head_q + AddrW'(1);
          end
        end else if (grow_rej) begin
          // Frame too long: drop the header and scan again from the next word.
          head_d  = head_q + AddrW'(1);
          cnt_d   = '0;
          avail_d = avail_q + cnt_q - CntW'(1);
        end else begin
          cnt_d   = cnt_q + CntW'(1);
          avail_d = avail_q - CntW'(1);
          sum_d   = sum_new;
          sh_d[0] = cur_byte;
          sh_d[1] = sh_q[0];
          sh_d[2] = sh_q[1];
          sh_d[3] = sh_q[2];
          if (cnt_q == CntW'(3)) begin
            len_d = cur_byte;
          end
          if (cnt_q >= CntW'(FrameMin - 1)) begin
            if (len_rej || (frame_done && !sum_ok)) begin
              head_d  = head_q + AddrW'(1);
              cnt_d   = '0;
              avail_d = avail_q + cnt_q - CntW'(1);
            end else if (frame_done) begin
              idx_d = '0;
            end
          end
        end

        if ((cnt_q != '0) && !grow_rej && (cnt_q >= CntW'(FrameMin - 1)) &&
            !len_rej && frame_done && sum_ok) begin
          state_d = StErd;
        end else if (avail_d == '0) begin
          state_d = StIdle;
        end else begin
          state_d = StRead;
        end
      end

      StErd: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = head_q + idx_q;
        state_d         = StEout;
      end

      StEout: begin
        if (out_ready_i) begin
          if (emit_last) begin
            head_d  = head_q + cnt_q[AddrW-1:0];
            cnt_d   = '0;
            state_d = (avail_q == '0) ? StIdle : StRead;
          end else begin
            idx_d   = idx_q + 6'd1;
            state_d = StErd;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      head_q    <= '0;
      cnt_q     <= '0;
      avail_q   <= '0;
      idx_q     <= '0;
      byp_sel_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      avail_q   <= avail_d;
      idx_q     <= idx_d;
      byp_sel_q <= byp_sel_d;
    end
  end

  // Frame payload tracking.
  always_ff @(posedge clk_i) begin
    byp_q <= byp_d;
    sum_q <= sum_d;
    len_q <= len_d;
    sh_q  <= sh_d;
  end

endmodule

### test/header_length_checksum_deframer_tb.sv
`timescale 1ns / 1ps

module header_length_checksum_deframer_tb;
  import hlcd_pkg::*;

  // Cycles the block may still spend on buffered words after its last frame word.
  localparam int SettleCycles = 600;
  localparam logic [7:0] TrailerCr = 8'h0D;
  localparam logic [7:0] TrailerLf = 8'h0A;

  // Mirror of the deframer: holds the open frame and the frame words still to come.
  class deframe_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic [5:0] pos;
      logic       last;
    } frame_word_t;

    logic [7:0]  frame_store [FrameMax];
    int unsigned held;
    logic [15:0] body_sum;
    logic [7:0]  header;
    logic [6:0]  limit;
    logic [7:0]  scan_q [$];
    frame_word_t expected_words [$];
    int unsigned mismatches;
    int unsigned words_seen;

    function new();
      header      = 8'h3A;
      limit       = 7'd64;
      held        = 0;
      body_sum    = '0;
      mismatches  = 0;
      words_seen  = 0;
    endfunction

    function void set_reg(logic idx, logic [7:0] value);
      if (idx == RegHeader) begin
        header = value;
      end else begin
        limit = value[6:0];
      end
    endfunction

    function int unsigned outstanding();
      return expected_words.size();
    endfunction

    // A rejected frame loses its header; everything after it goes back in front of
    // the words still waiting to be scanned.
    function void drop_header(bit with_extra, logic [7:0] extra);
      logic [7:0] tmp [$];
      int unsigned i;
      for (i = 1; i < held; i++) tmp.push_back(frame_store[i]);
      if (with_extra) tmp.push_back(extra);
      while (scan_q.size() > 0) tmp.push_back(scan_q.pop_front());
      scan_q   = tmp;
      held     = 0;
      body_sum = '0;
    endfunction

    // Called for every word the block takes on its input.
    function void take_rx_byte(logic [7:0] rx);
      int unsigned lim;
      int unsigned len;
      int unsigned i;
      logic [15:0] calc;
      logic [15:0] got;
      logic [7:0]  b;
      frame_word_t w;
      lim = (limit > FrameMax) ? FrameMax : limit;
      scan_q.delete();
      scan_q.push_back(rx);
      while (scan_q.size() > 0) begin
        b = scan_q.pop_front();
        if (held == 0) begin
          // Only the header value opens a frame; anything else is dropped.
          if (b == header) begin
            frame_store[0] = b;
            held           = 1;
            body_sum       = '0;
          end
        end else if (held >= lim) begin
          // The frame would grow past the limit; this word is scanned again too.
          drop_header(1'b1, b);
        end else begin
          frame_store[held] = b;
          held++;
          body_sum = body_sum + b;
          if (held >= FrameMin) begin
            len = frame_store[3];
            if (lim < FrameMin || len > lim - FrameMin) begin
              drop_header(1'b0, 8'h00);
            end else if (held >= len + FrameMin) begin
              // Sum covers address through payload: drop the sum and trailer words.
              calc = body_sum;
              for (i = held - 4; i < held; i++) calc = calc - frame_store[i];
              got = {frame_store[held-3], frame_store[held-4]};
              if (calc != got) begin
                drop_header(1'b0, 8'h00);
              end else begin
                for (i = 0; i < held; i++) begin
                  w.data = frame_store[i];
                  w.pos  = i[5:0];
                  w.last = (i + 1 == held);
                  expected_words.push_back(w);
                end
                held     = 0;
                body_sum = '0;
              end
            end
          end
        end
      end
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR: %s", msg);
    endfunction

    // Called for every frame word the block hands out.
    function void check_frame_word(logic [7:0] data, logic [5:0] pos, logic last);
      frame_word_t w;
      words_seen++;
      if (expected_words.size() == 0) begin
        note_mismatch($sformatf("word %0d: unexpected, got byte %02h pos %0d last %0b",
                                words_seen, data, pos, last));
      end else begin
        w = expected_words.pop_front();
        if (w.data !== data || w.pos !== pos || w.last !== last) begin
          note_mismatch($sformatf(
            "word %0d: expected byte %02h pos %0d last %0b, got byte %02h pos %0d last %0b",
            words_seen, w.data, w.pos, w.last, data, pos, last));
        end
      end
    endfunction

    function void check_leftover();
      if (expected_words.size() != 0) begin
        note_mismatch($sformatf("%0d frame words never arrived", expected_words.size()));
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;    // [7:0] frame_byte, [13:8] byte_position, [15:14] zero
  logic        m_tlast;

  deframe_scoreboard frame_check = new();

  logic [7:0] tx_bytes [$];
  logic [7:0] cur_hdr;
  int         cur_lim;
  int         burst_left;
  int         rx_hold_cycles;

  header_length_checksum_deframer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog for a hung run.
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: switches between stall patterns and honors a requested long hold-off.
  initial begin : frame_sink
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && m_tvalid === 1'b1 && m_tready) begin
        frame_check.check_frame_word(m_tdata[7:0], m_tdata[13:8], m_tlast);
      end
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(2);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          0: begin
            m_tready <= 1'b1;
          end
          1: begin
            m_tready <= ($urandom_range(99) < 60);
          end
          default: begin
            m_tready <= (mode_left % 4 == 0);
          end
        endcase
      end
    end
  end

  // Offers one word and waits until it is taken; called and returns at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    s_tdata  <= b;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (s_tready !== 1'b1);
    frame_check.take_rx_byte(b);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(7) == 0) ? 80 : $urandom_range(1, 24);
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  task automatic flush_tx();
    while (tx_bytes.size() > 0) send_byte(tx_bytes.pop_front());
  endtask

  // Stops sending and waits until every frame word has come and the scan has settled.
  task automatic wait_for_idle();
    s_tvalid <= 1'b0;
    while (frame_check.outstanding() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    frame_check.set_reg(idx, value);
    if (idx == RegHeader) begin
      cur_hdr = value;
    end else begin
      cur_lim = value[6:0];
    end
    @(negedge clk_i);
  endtask

  // Queues a frame, or only its first keep words when keep is not negative.
  function automatic void push_frame(input logic [7:0] hdr, input int plen,
                                     input bit corrupt, input int keep);
    logic [7:0]  fb [$];
    logic [15:0] sum;
    int          i;
    int          n;
    fb.push_back(hdr);
    fb.push_back(8'($urandom));
    fb.push_back(8'($urandom));
    fb.push_back(plen[7:0]);
    for (i = 0; i < plen; i++) fb.push_back(8'($urandom));
    sum = '0;
    for (i = 1; i < fb.size(); i++) sum = sum + fb[i];
    if (corrupt) sum = sum ^ (16'h0001 << $urandom_range(15));
    fb.push_back(sum[7:0]);
    fb.push_back(sum[15:8]);
    // The trailer is never checked, so now and then it carries junk.
    if ($urandom_range(7) == 0) begin
      fb.push_back(8'($urandom));
      fb.push_back(8'($urandom));
    end else begin
      fb.push_back(TrailerCr);
      fb.push_back(TrailerLf);
    end
    n = (keep < 0 || keep > fb.size()) ? fb.size() : keep;
    for (i = 0; i < n; i++) tx_bytes.push_back(fb[i]);
  endfunction

  // One phase of random traffic: mostly good frames, plus broken ones and line noise.
  task automatic run_phase(input logic [7:0] hdr, input int lim, input int n_items,
                           input bit with_hold, input bit with_pause);
    int counted;
    int r;
    int plen;
    int k;
    bit paused;
    counted = 0;
    paused  = 1'b0;
    wait_for_idle();
    write_reg(RegHeader, hdr);
    write_reg(RegLimit, lim[7:0]);
    if (with_hold) rx_hold_cycles = 700;
    while (counted < n_items) begin
      r = $urandom_range(99);
      if (r < 65) begin
        // Mostly small payloads, now and then up to the limit.
        if ($urandom_range(9) == 0) begin
          plen = $urandom_range(cur_lim - FrameMin);
        end else begin
          plen = $urandom_range((cur_lim - FrameMin < 6) ? cur_lim - FrameMin : 6);
        end
        push_frame(cur_hdr, plen, (r >= 55), -1);
        counted += plen + FrameMin;
      end else if (r < 73) begin
        // Length byte above what the limit allows.
        k = $urandom_range(4, 10);
        push_frame(cur_hdr, $urandom_range(cur_lim - 7, 255), 1'b0, k);
        counted += k;
      end else if (r < 82) begin
        // Frame cut short; the next frame runs into it.
        plen = $urandom_range(4);
        k    = $urandom_range(1, plen + FrameMin - 1);
        push_frame(cur_hdr, plen, 1'b0, k);
        counted += k;
      end else begin
        repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom));
      end
      flush_tx();
      if (with_pause && !paused && counted >= n_items / 2) begin
        paused = 1'b1;
        wait_for_idle();
      end
    end
  endtask

  // Stimulus and end of run.
  initial begin : stimulus
    int i;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = RegHeader;
    cfg_wdata_i    = 8'h00;
    s_tvalid       = 1'b0;
    s_tdata        = 8'h00;
    cur_hdr        = 8'h3A;
    cur_lim        = 64;
    burst_left     = 0;
    rx_hold_cycles = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Stray words before any header, then the shortest and the longest frame.
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'h3B);
    push_frame(cur_hdr, 0, 1'b0, -1);
    push_frame(cur_hdr, cur_lim - FrameMin, 1'b0, -1);
    // Length byte one past the limit, then a checksum error.
    push_frame(cur_hdr, cur_lim - FrameMin + 1, 1'b0, 9);
    push_frame(cur_hdr, 3, 1'b1, -1);
    // A bad outer frame whose payload holds two good frames: both come out on rescan.
    tx_bytes.push_back(cur_hdr);
    tx_bytes.push_back(8'h11);
    tx_bytes.push_back(8'h22);
    tx_bytes.push_back(8'd16);
    push_frame(cur_hdr, 0, 1'b0, -1);
    push_frame(cur_hdr, 0, 1'b0, -1);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(TrailerCr);
    tx_bytes.push_back(TrailerLf);
    flush_tx();

    // Open a long frame, then lower the limit under it so the next word overflows it.
    tx_bytes.push_back(cur_hdr);
    tx_bytes.push_back(8'h01);
    tx_bytes.push_back(8'h02);
    tx_bytes.push_back(8'd40);
    for (i = 0; i < 10; i++) tx_bytes.push_back(8'($urandom));
    flush_tx();
    wait_for_idle();
    write_reg(RegLimit, 8'd8);
    push_frame(cur_hdr, 0, 1'b0, -1);
    push_frame(cur_hdr, 0, 1'b0, -1);
    flush_tx();

    // Extreme header values.
    wait_for_idle();
    write_reg(RegLimit, 8'd64);
    write_reg(RegHeader, 8'hFF);
    push_frame(cur_hdr, 2, 1'b0, -1);
    flush_tx();
    wait_for_idle();
    write_reg(RegHeader, 8'h00);
    push_frame(cur_hdr, 1, 1'b0, -1);
    flush_tx();

    // Random phases over several settings.
    run_phase(8'h3A, 64, 36, 1'b1, 1'b0);
    run_phase(8'h00, 8, 26, 1'b0, 1'b1);
    run_phase(8'hFF, 33, 28, 1'b0, 1'b0);
    run_phase(8'($urandom), $urandom_range(8, 64), 28, 1'b0, 1'b0);
    run_phase(8'h3A, 64, 36, 1'b1, 1'b1);

    wait_for_idle();
    frame_check.check_leftover();
    if (frame_check.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
